>>> sv/hufd_pkg.sv
// ----------------------------------------------------------------------------
// hufd_pkg
// Types, constants and phase codes shared by the Huffman stream decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hufd_pkg;

  localparam int MAX_NODES_DEF   = 512;
  localparam int STACK_DEPTH_DEF = 256;

  localparam int SYM_W   = 8;
  localparam int COUNT_W = 24;

  localparam int RSP_FIFO_DEPTH = 4;
  localparam int RSP_PTR_W      = 2;
  localparam int RSP_LEVEL_W    = 3;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_BIT   = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_DECODE = 2'd2,
    PH_HALT   = 2'd3
  } phase_t;

  typedef struct packed {
    logic               command;
    logic               data_bit;
    logic [COUNT_W-1:0] symbol_count;
  } req_t;

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [COUNT_W-1:0] repeat_res;
    logic               last;
    logic               error;
  } rsp_t;

endpackage

`default_nettype wire

>>> sv/hufd_ram.sv
// ----------------------------------------------------------------------------
// hufd_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/hufd_rsp_fifo.sv
// ----------------------------------------------------------------------------
// hufd_rsp_fifo
// Small result queue that decouples the decode pipeline from the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module hufd_rsp_fifo (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire hufd_pkg::rsp_t                     wdata,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output hufd_pkg::rsp_t                          rsp,
  output logic [hufd_pkg::RSP_LEVEL_W-1:0]        level
);

  hufd_pkg::rsp_t                      mem [hufd_pkg::RSP_FIFO_DEPTH];
  logic [hufd_pkg::RSP_PTR_W-1:0]      wr_ptr;
  logic [hufd_pkg::RSP_PTR_W-1:0]      rd_ptr;
  logic                                pop;

  assign rsp_valid = (level != '0);
  assign rsp       = mem[rd_ptr];
  assign pop       = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

>>> sv/huffman_tree_stream_decoder_core.sv
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder_core
// Parses a preorder code tree header into node memories and then walks the
// tree one compressed bit per word, emitting decoded symbols.
// ----------------------------------------------------------------------------
// Throughput is one request word per cycle while the result queue has room;
// the limit is the node memory read whose data selects the next node address
// in the following cycle. A result is valid on rsp once the node read for the
// word that completes it has resolved and been written into the result queue.
// Reset is synchronous and clears the control state; the node and stack
// memories are not cleared and are written during each header.
`default_nettype none

module huffman_tree_stream_decoder_core #(
  parameter int MAX_NODES   = hufd_pkg::MAX_NODES_DEF,
  parameter int STACK_DEPTH = hufd_pkg::STACK_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_ready,
  input  wire hufd_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_ready,
  output hufd_pkg::rsp_t      rsp
);

  localparam int NODE_AW = $clog2(MAX_NODES);
  localparam int NCNT_W  = $clog2(MAX_NODES + 1);
  localparam int STK_AW  = $clog2(STACK_DEPTH);
  localparam int SDEP_W  = $clog2(STACK_DEPTH + 1);
  localparam int LS_W    = hufd_pkg::SYM_W + 1;
  localparam int CW      = hufd_pkg::COUNT_W;
  localparam int SW      = hufd_pkg::SYM_W;
  localparam int LW      = hufd_pkg::RSP_LEVEL_W;

  hufd_pkg::phase_t phase, phase_next, phase_eff;
  logic [NCNT_W-1:0]  nodes_used, nodes_used_next;
  logic [SDEP_W-1:0]  depth, depth_next;
  logic [3:0]         lbs, lbs_next;
  logic [SW-1:0]      shift, shift_next, shift_new;
  logic [NODE_AW-1:0] cur, cur_next, eff_cur;
  logic [NCNT_W-1:0]  cur_rc, cur_rc_next, eff_rc;
  logic [NCNT_W-1:0]  root_rc, root_rc_next;
  logic               root_leaf, root_leaf_next;
  logic [CW-1:0]      symbols_left, symbols_left_next, sl_eff, sl_dec;
  logic               s2_dec, s2_dec_next;
  logic               s2_dir, s2_dir_next;
  logic [NODE_AW-1:0] s2_idx, s2_idx_next;
  hufd_pkg::rsp_t     s2_res, s2_res_next;

  logic               accept;
  logic               s2_leaf;
  logic               s2_last;
  logic [NCNT_W-1:0]  step, next_c;

  logic               ls_we;
  logic [NODE_AW-1:0] ls_waddr;
  logic [LS_W-1:0]    ls_wdata, ls_rdata;
  logic               rc_we;
  logic [NODE_AW-1:0] rc_waddr;
  logic [NCNT_W-1:0]  rc_wdata, rc_rdata;
  logic [NODE_AW-1:0] node_raddr;
  logic               stk_we;
  logic [STK_AW-1:0]  stk_waddr, stk_raddr;
  logic [NODE_AW-1:0] stk_wdata, stk_rdata;

  logic               push;
  hufd_pkg::rsp_t     push_data;
  logic [LW-1:0]      level, level_sum;

  hufd_ram #(.WIDTH(LS_W), .DEPTH(MAX_NODES)) u_leaf_sym (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
    .raddr(node_raddr), .rdata(ls_rdata)
  );

  hufd_ram #(.WIDTH(NCNT_W), .DEPTH(MAX_NODES)) u_right_child (
    .clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
    .raddr(node_raddr), .rdata(rc_rdata)
  );

  hufd_ram #(.WIDTH(NODE_AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  hufd_rsp_fifo u_rsp_fifo (
    .clk(clk), .rst(rst), .push(push), .wdata(push_data),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp), .level(level)
  );

  // The stack top is read continuously; depth stays put for a whole leaf.
  assign stk_raddr = STK_AW'(depth - 1'b1);

  assign level_sum = level + LW'(s2_dec | s2_dir);
  assign req_ready = (level_sum <= LW'(2));
  assign accept    = req_valid && req_ready;

  assign shift_new = {shift[SW-2:0], req.data_bit};

  // Resolution of the node read issued for the previous word.
  always_comb begin
    s2_leaf   = s2_dec && ls_rdata[SW];
    sl_dec    = symbols_left - 1'b1;
    s2_last   = s2_leaf && (sl_dec == '0);
    eff_cur   = s2_dec ? (s2_leaf ? '0 : s2_idx) : cur;
    eff_rc    = s2_dec ? (s2_leaf ? root_rc : rc_rdata) : cur_rc;
    sl_eff    = s2_leaf ? sl_dec : symbols_left;
    phase_eff = s2_last ? hufd_pkg::PH_IDLE : phase;
    push      = s2_dir || s2_leaf;
    if (s2_dir) begin
      push_data = s2_res;
    end else begin
      push_data.symbol     = ls_rdata[SW-1:0];
      push_data.repeat_res = CW'(1);
      push_data.last       = s2_last;
      push_data.error      = 1'b0;
    end
  end

  always_comb begin
    step       = req.data_bit ? eff_rc : (NCNT_W'(eff_cur) + 1'b1);
    next_c     = (step >= NCNT_W'(MAX_NODES)) ? '0 : step;
    node_raddr = next_c[NODE_AW-1:0];
  end

  always_comb begin
    phase_next = phase_eff;
    if (accept) begin
      if (req.command == hufd_pkg::CMD_START) begin
        phase_next = (req.symbol_count == '0) ? hufd_pkg::PH_IDLE : hufd_pkg::PH_HEADER;
      end else begin
        case (phase_eff)
          hufd_pkg::PH_HEADER: begin
            if (lbs != '0) begin
              if (lbs == 4'd8 && depth == '0) begin
                phase_next = root_leaf ? hufd_pkg::PH_IDLE : hufd_pkg::PH_DECODE;
              end
            end else if (nodes_used == NCNT_W'(MAX_NODES)) begin
              phase_next = hufd_pkg::PH_HALT;
            end else if (!req.data_bit && depth == SDEP_W'(STACK_DEPTH)) begin
              phase_next = hufd_pkg::PH_HALT;
            end
          end
          default: phase_next = phase_eff;
        endcase
      end
    end
  end

  always_comb begin
    nodes_used_next   = nodes_used;
    depth_next        = depth;
    lbs_next          = lbs;
    shift_next        = shift;
    cur_next          = eff_cur;
    cur_rc_next       = eff_rc;
    root_rc_next      = root_rc;
    root_leaf_next    = root_leaf;
    symbols_left_next = sl_eff;
    s2_dec_next       = 1'b0;
    s2_dir_next       = 1'b0;
    s2_idx_next       = s2_idx;
    s2_res_next       = s2_res;
    ls_we             = 1'b0;
    ls_waddr          = NODE_AW'(nodes_used);
    ls_wdata          = '0;
    rc_we             = 1'b0;
    rc_waddr          = stk_rdata;
    rc_wdata          = nodes_used;
    stk_we            = 1'b0;
    stk_waddr         = STK_AW'(depth);
    stk_wdata         = NODE_AW'(nodes_used);
    if (accept) begin
      if (req.command == hufd_pkg::CMD_START) begin
        nodes_used_next   = '0;
        depth_next        = '0;
        lbs_next          = '0;
        shift_next        = '0;
        cur_next          = '0;
        cur_rc_next       = root_rc;
        symbols_left_next = req.symbol_count;
      end else begin
        case (phase_eff)
          hufd_pkg::PH_HEADER: begin
            if (lbs != '0) begin
              shift_next = shift_new;
              lbs_next   = lbs + 1'b1;
              if (lbs == 4'd8) begin
                lbs_next = '0;
                ls_we    = 1'b1;
                ls_waddr = NODE_AW'(nodes_used - 1'b1);
                ls_wdata = {1'b1, shift_new};
                if (depth != '0) begin
                  depth_next = depth - 1'b1;
                  rc_we      = 1'b1;
                  if (stk_rdata == '0) begin
                    root_rc_next = nodes_used;
                  end
                end else begin
                  cur_next    = '0;
                  cur_rc_next = root_rc;
                  if (root_leaf) begin
                    s2_dir_next            = 1'b1;
                    s2_res_next.symbol     = shift_new;
                    s2_res_next.repeat_res = sl_eff;
                    s2_res_next.last       = 1'b1;
                    s2_res_next.error      = 1'b0;
                    symbols_left_next      = '0;
                  end
                end
              end
            end else if (nodes_used == NCNT_W'(MAX_NODES)) begin
              s2_dir_next = 1'b1;
              s2_res_next = '{symbol: '0, repeat_res: '0, last: 1'b1, error: 1'b1};
            end else begin
              nodes_used_next = nodes_used + 1'b1;
              if (nodes_used == '0) begin
                root_leaf_next = req.data_bit;
              end
              if (req.data_bit) begin
                lbs_next   = 4'd1;
                shift_next = '0;
              end else if (depth == SDEP_W'(STACK_DEPTH)) begin
                s2_dir_next = 1'b1;
                s2_res_next = '{symbol: '0, repeat_res: '0, last: 1'b1, error: 1'b1};
              end else begin
                stk_we     = 1'b1;
                depth_next = depth + 1'b1;
                ls_we      = 1'b1;
              end
            end
          end
          hufd_pkg::PH_DECODE: begin
            s2_dec_next = 1'b1;
            s2_idx_next = next_c[NODE_AW-1:0];
          end
          default: s2_dec_next = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= hufd_pkg::PH_IDLE;
      nodes_used   <= '0;
      depth        <= '0;
      lbs          <= '0;
      shift        <= '0;
      cur          <= '0;
      symbols_left <= '0;
      s2_dec       <= 1'b0;
      s2_dir       <= 1'b0;
    end else begin
      phase        <= phase_next;
      nodes_used   <= nodes_used_next;
      depth        <= depth_next;
      lbs          <= lbs_next;
      shift        <= shift_next;
      cur          <= cur_next;
      symbols_left <= symbols_left_next;
      s2_dec       <= s2_dec_next;
      s2_dir       <= s2_dir_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_rc    <= cur_rc_next;
    root_rc   <= root_rc_next;
    root_leaf <= root_leaf_next;
    s2_idx    <= s2_idx_next;
    s2_res    <= s2_res_next;
  end

`ifndef SYNTH
  a_s2_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(s2_dec && s2_dir))
    else $error("Node read and direct result in flight together.");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= SDEP_W'(STACK_DEPTH))
    else $error("Pending stack depth beyond its size.");

  a_decode_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == hufd_pkg::PH_DECODE) |-> (depth == '0 && lbs == '0))
    else $error("Decoding with an unfinished tree header.");

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    level_sum <= LW'(hufd_pkg::RSP_FIFO_DEPTH))
    else $error("Result queue could overflow.");
`endif

endmodule

`default_nettype wire
